[sv/cse_pkg.sv]
// Package for the column statistics engine: widths, mode codes and the
// record passed from the front accumulator to the back finisher. No dependencies.
`default_nettype none
package cse_pkg;
    localparam int MaxRows     = 1024;
    localparam int SampleWidth = 24;
    localparam int CountWidth  = $clog2(MaxRows + 1);
    localparam int ValueWidth  = 34;
    localparam int SquareWidth = 57;

    typedef enum logic [2:0] {
        MODE_MEAN  = 3'd0,
        MODE_SIGMA = 3'd1,
        MODE_SUM   = 3'd2,
        MODE_MIN   = 3'd3,
        MODE_MAX   = 3'd4,
        MODE_FIRST = 3'd5,
        MODE_RSUM  = 3'd6,
        MODE_RDIFF = 3'd7
    } t_mode;

    // One job for the back part: a direct value or a column summary.
    typedef struct packed {
        logic                          direct;
        t_mode                         mode;
        logic                          ovf;
        logic signed [ValueWidth-1:0]  value;
        logic [CountWidth-1:0]         count;
        logic [SquareWidth-1:0]        sq;
    } t_job;
endpackage
`default_nettype wire

[sv/cse_front.sv]
// Front part: accepts samples, updates the column accumulators and issues
// jobs into the queue. Depends on cse_pkg.
`default_nettype none
module cse_front
    import cse_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_mode                  i_mode,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [SampleWidth-1:0] i_sample,
    input  wire logic                   i_last,
    output logic                        o_job_valid,
    input  wire logic                   i_job_ready,
    output t_job                        o_job
);
    logic [CountWidth-1:0]        r_count;
    logic signed [ValueWidth-1:0] r_total;
    logic [SquareWidth-1:0]       r_sq;
    logic signed [SampleWidth-1:0] r_min, r_max, r_first, r_prev;
    logic r_ovf;

    logic signed [SampleWidth-1:0] x;
    logic take, full, ovf_now;
    logic signed [ValueWidth-1:0] n_total;
    logic [SquareWidth-1:0] n_sq;
    logic [2*SampleWidth-1:0] sq_term;
    logic [SampleWidth-1:0] mag;
    logic signed [ValueWidth-1:0] diff;

    assign x       = i_sample;
    assign o_ready = i_job_ready;
    assign take    = i_valid && i_job_ready;
    assign full    = (r_count >= CountWidth'(MaxRows));
    assign ovf_now = r_ovf || full;
    assign mag     = x[SampleWidth-1] ? SampleWidth'(-x) : SampleWidth'(x);
    assign sq_term = mag * mag;
    assign n_total = full ? r_total : r_total + ValueWidth'(x);
    assign n_sq    = full ? r_sq : r_sq + SquareWidth'(sq_term);
    assign diff    = ValueWidth'(x) - ValueWidth'(r_prev);

    // Job issue: running modes every item, others on the last item.
    always_comb begin
        o_job        = '0;
        o_job.mode   = i_mode;
        o_job.ovf    = ovf_now;
        o_job.count  = full ? r_count : r_count + 1'b1;
        o_job.sq     = n_sq;
        o_job.direct = 1'b1;
        o_job.value  = n_total;
        o_job_valid  = i_valid;
        unique case (i_mode)
            MODE_RSUM:  o_job.value = n_total;
            MODE_RDIFF: o_job.value = diff;
            MODE_MIN: o_job.value = ValueWidth'((r_count == '0) ? x :
                                     (!full && x < r_min) ? x : r_min);
            MODE_MAX: o_job.value = ValueWidth'((r_count == '0) ? x :
                                     (!full && x > r_max) ? x : r_max);
            MODE_FIRST: o_job.value = ValueWidth'((r_count == '0) ? x : r_first);
            MODE_SUM: o_job.value = n_total;
            default: begin
                o_job.direct = 1'b0;
                o_job.value  = n_total;
            end
        endcase
        if (i_mode != MODE_RSUM && i_mode != MODE_RDIFF && !i_last)
            o_job_valid = 1'b0;
    end

    // Accumulators; cleared after the last item of a column.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (take && i_last)) begin
            r_count <= '0; r_total <= '0; r_sq <= '0; r_ovf <= 1'b0;
            r_min <= '0; r_max <= '0; r_first <= '0; r_prev <= '0;
        end else if (take) begin
            r_prev <= x;
            if (full) begin
                r_ovf <= 1'b1;
            end else begin
                r_count <= r_count + 1'b1;
                r_total <= n_total;
                r_sq    <= n_sq;
                if (r_count == '0) begin
                    r_min <= x; r_max <= x; r_first <= x;
                end else if (x < r_min) begin
                    r_min <= x;
                end else if (x > r_max) begin
                    r_max <= x;
                end
            end
        end
    end
endmodule
`default_nettype wire

[sv/cse_queue.sv]
// Two-entry queue between front and back parts. Depends on cse_pkg.
`default_nettype none
module cse_queue
    import cse_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_job i_job,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_job      o_job
);
    t_job r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_fill;
    logic push, pop;

    assign o_ready = (r_fill != 2'd2);
    assign o_valid = (r_fill != 2'd0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_fill <= '0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_fill <= r_fill + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

[sv/cse_back.sv]
// Back part: passes direct values, or works out mean and sigma with a
// bit-serial divider and square root. Depends on cse_pkg.
`default_nettype none
module cse_back
    import cse_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire t_job                    i_job,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic signed [ValueWidth-1:0] o_value,
    output logic                         o_ovf
);
    localparam int NumW = 128;
    localparam int DenW = 2 * CountWidth;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001, S_MUL1 = 7'b0000010, S_MUL2 = 7'b0000100,
        S_SUB  = 7'b0001000, S_DIV  = 7'b0010000, S_SQRT = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state r_state;
    t_job   r_job;
    logic [NumW-1:0]       r_num, r_a, r_b;
    logic [DenW:0]         r_rem;
    logic [DenW-1:0]       r_den;
    logic [6:0]            r_step;
    logic [63:0]           r_x, r_root, r_bit;
    logic signed [ValueWidth-1:0] r_value;
    logic                  r_ovf, r_full;
    logic [ValueWidth-1:0] r_mag;
    logic                  r_neg;

    logic [DenW:0] trial;
    logic [63:0]   sq_sum;

    assign o_ready = (r_state == S_IDLE) && !r_full;
    assign o_valid = r_full;
    assign o_value = r_value;
    assign o_ovf   = r_ovf;
    assign trial   = {r_rem[DenW-1:0], r_num[NumW-1]};
    assign sq_sum  = r_root + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_full  <= 1'b0;
        end else begin
            if (r_full && i_ready) r_full <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_valid && !r_full) begin
                    r_job <= i_job;
                    if (i_job.direct) begin
                        r_value <= i_job.value;
                        r_ovf   <= i_job.ovf;
                        r_full  <= 1'b1;
                    end else begin
                        r_state <= S_MUL1;
                    end
                end
                // Products n*Sq and S*S, or |S| as numerator for the mean.
                S_MUL1: begin
                    r_neg <= r_job.value[ValueWidth-1];
                    r_mag <= r_job.value[ValueWidth-1] ? -r_job.value : r_job.value;
                    r_a   <= NumW'(r_job.sq) * NumW'(r_job.count);
                    r_den <= DenW'(r_job.count) *
                             DenW'((r_job.count < CountWidth'(2)) ? CountWidth'(1)
                                   : r_job.count - 1'b1);
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_b <= NumW'(r_mag) * NumW'(r_mag);
                    r_state <= S_SUB;
                end
                S_SUB: begin
                    if (r_job.mode == MODE_MEAN) begin
                        r_num <= NumW'(r_mag);
                        r_den <= DenW'(r_job.count);
                    end else begin
                        r_num <= (r_b > r_a) ? '0 : r_a - r_b;
                    end
                    r_rem  <= '0;
                    r_step <= '0;
                    r_state <= S_DIV;
                end
                // Restoring division, one quotient bit per cycle.
                S_DIV: begin
                    if (trial >= {1'b0, r_den}) begin
                        r_rem <= trial - {1'b0, r_den};
                        r_num <= {r_num[NumW-2:0], 1'b1};
                    end else begin
                        r_rem <= trial;
                        r_num <= {r_num[NumW-2:0], 1'b0};
                    end
                    if (r_step == 7'd127) begin
                        if (r_job.mode == MODE_MEAN) begin
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_SQRT;
                            r_root  <= '0;
                            r_bit   <= 64'h4000_0000_0000_0000;
                            r_step  <= '0;
                        end
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                // Square root, two bits of radicand per cycle.
                S_SQRT: begin
                    if (r_step == 7'd0) begin
                        r_x <= (r_num[127:64] != '0) ? '1 : r_num[63:0];
                        r_step <= 7'd1;
                    end else if (r_bit == '0) begin
                        r_state <= S_OUT;
                    end else begin
                        if (r_x >= sq_sum) begin
                            r_x    <= r_x - sq_sum;
                            r_root <= (r_root >> 1) + r_bit;
                        end else begin
                            r_root <= r_root >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end
                end
                S_OUT: if (!r_full) begin
                    if (r_job.mode == MODE_MEAN)
                        r_value <= r_neg ? -ValueWidth'(r_num) : ValueWidth'(r_num);
                    else
                        r_value <= ValueWidth'(r_root);
                    r_ovf   <= r_job.ovf;
                    r_full  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[sv/column_statistics_engine_core.sv]
// Top level of the column statistics engine: front accumulator, job queue
// and back finisher. Depends on cse_pkg, cse_front, cse_queue, cse_back.
//
//  channel  direction  tdata (low bit up)        tuser
//  s_axis   in         sample[23:0]              -      tlast = last_of_column
//  m_axis   out        value[33:0], zero pad     overflow
//  cfg      in         op_mode[2:0] via i_cfg_we / i_cfg_wdata
//
// Samples are taken one per cycle while the queue has room; running and simple
// results pass through the queue and the back part's output register. A mean is
// offered after the last item once the bit-serial divider in the back part has
// run, a sigma once the divider and square root have. Synchronous active-low
// reset clears all control state. Each side stalls on its own; the queue holds
// two jobs, and once it is full the input stalls until the back part takes one.
`default_nettype none
module column_statistics_engine_core
    import cse_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // sample[23:0]
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,  // value[33:0], zeros above
    output logic             m_axis_tuser   // overflow
);
    t_mode r_mode;
    t_job  f_job, q_job;
    logic  f_valid, f_ready, q_valid, q_ready;
    logic signed [ValueWidth-1:0] b_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_mode <= MODE_MEAN;
        else if (i_cfg_we) r_mode <= t_mode'(i_cfg_wdata);
    end

    cse_front u_front (
        .i_clk, .i_rst_n, .i_mode(r_mode),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_sample(s_axis_tdata), .i_last(s_axis_tlast),
        .o_job_valid(f_valid), .i_job_ready(f_ready), .o_job(f_job)
    );

    cse_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(f_valid), .o_ready(f_ready), .i_job(f_job),
        .o_valid(q_valid), .i_ready(q_ready), .o_job(q_job)
    );

    cse_back u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .o_ready(q_ready), .i_job(q_job),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_value(b_value), .o_ovf(m_axis_tuser)
    );

    assign m_axis_tdata = {6'd0, b_value};
endmodule
`default_nettype wire

[dv/tb_column_statistics_engine_core.sv]
// Self-checking testbench for column_statistics_engine_core: streams columns of
// signed samples, predicts every statistic and compares it with the output stream.
// Depends on cse_pkg and the column_statistics_engine_core RTL.
`default_nettype none
module tb_column_statistics_engine_core;
    import cse_pkg::*;

    typedef struct {
        logic [23:0] sample;
        bit          last;
    } t_sample_item;

    typedef struct {
        logic [33:0] value;
        bit          ovf;
    } t_stat_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_wdata = 3'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = 24'd0;   // sample[23:0]
    logic        s_axis_tlast = 1'b0;    // last_of_column
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;           // value[33:0], zeros above
    logic        m_axis_tuser;           // overflow

    column_statistics_engine_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Stimulus and result bookkeeping.
    t_sample_item sample_q[$];
    t_stat_result stat_q[$];
    t_sample_item drive_item;
    t_stat_result got_item;
    t_stat_result want_item;
    int  errors = 0;
    int  items_in = 0;
    int  results_out = 0;
    int  columns_pushed = 0;
    int  items_pushed = 0;
    bit  calm = 1'b0;
    bit  start_stall = 1'b0;
    int  stall_left = 0;

    // Predictor copy of the column state.
    t_mode            mode_now = MODE_MEAN;
    int               col_count = 0;
    logic [33:0]      col_total = '0;
    logic [56:0]      col_squares = '0;
    longint           col_min = 0;
    longint           col_max = 0;
    longint           col_first = 0;
    longint           col_prev = 0;
    bit               col_ovf = 1'b0;

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Sample standard deviation from count, sum and sum of squares.
    function automatic logic [63:0] column_sigma(input longint total);
        logic [127:0] scaled_sq;
        logic [127:0] sum_sq;
        logic [127:0] numer;
        logic [127:0] quot;
        logic [63:0]  mag;
        longint       denom;
        denom = longint'(col_count) * ((col_count < 2) ? 1 : longint'(col_count - 1));
        scaled_sq = 128'(col_count) * 128'(col_squares);
        mag = (total < 0) ? 64'(-total) : 64'(total);
        sum_sq = 128'(mag) * 128'(mag);
        numer = (scaled_sq >= sum_sq) ? scaled_sq - sum_sq : '0;
        quot = numer / 128'(denom);
        return floor_sqrt((quot[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : quot[63:0]);
    endfunction

    // Advance the column state by one accepted sample and queue any result.
    function automatic void predict_statistic(input t_sample_item it);
        longint       x;
        longint       diff;
        longint       total;
        longint       res;
        bit           emit;
        t_stat_result r;
        x = longint'($signed(it.sample));
        diff = x - col_prev;
        res = 0;
        emit = 1'b0;
        if (col_count >= MaxRows) begin
            col_ovf = 1'b1;
        end else begin
            if (col_count == 0) begin
                col_min = x;
                col_max = x;
                col_first = x;
            end else if (x < col_min) begin
                col_min = x;
            end else if (x > col_max) begin
                col_max = x;
            end
            col_total = col_total + 34'(x);
            col_squares = col_squares + 57'(x * x);
            col_count++;
        end
        col_prev = x;
        total = longint'($signed(col_total));
        if (mode_now == MODE_RSUM) begin
            res = total;
            emit = 1'b1;
        end else if (mode_now == MODE_RDIFF) begin
            res = diff;
            emit = 1'b1;
        end else if (it.last) begin
            emit = 1'b1;
            case (mode_now)
                MODE_MEAN:  res = total / longint'(col_count);
                MODE_SIGMA: res = longint'(column_sigma(total));
                MODE_SUM:   res = total;
                MODE_MIN:   res = col_min;
                MODE_MAX:   res = col_max;
                default:    res = col_first;
            endcase
        end
        if (emit) begin
            r.value = 34'(res);
            r.ovf = col_ovf;
            stat_q.push_back(r);
        end
        if (it.last) begin
            col_count = 0;
            col_total = '0;
            col_squares = '0;
            col_min = 0;
            col_max = 0;
            col_first = 0;
            col_prev = 0;
            col_ovf = 1'b0;
        end
    endfunction

    // Sender: offers queued samples, holding each until it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                drive_item.sample = s_axis_tdata;
                drive_item.last = s_axis_tlast;
                predict_statistic(drive_item);
                items_in++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (sample_q.size() != 0 && (calm || $urandom_range(0, 99) >= 7)) begin
                    drive_item = sample_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= drive_item.sample;
                    s_axis_tlast <= drive_item.last;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted down here.
    always @(posedge i_clk) begin
        if (start_stall) stall_left <= 400;
        else if (stall_left > 0) stall_left <= stall_left - 1;
    end

    // Receiver: random back-pressure and field-by-field check of each result.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_item.value = m_axis_tdata[33:0];
                got_item.ovf = m_axis_tuser;
                results_out++;
                if (stat_q.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result value=%h", got_item.value));
                end else begin
                    want_item = stat_q.pop_front();
                    if (got_item.value !== want_item.value)
                        flag_mismatch($sformatf("value got %h want %h",
                                                got_item.value, want_item.value));
                    if (got_item.ovf !== want_item.ovf)
                        flag_mismatch($sformatf("overflow got %b want %b",
                                                got_item.ovf, want_item.ovf));
                    if (m_axis_tdata[39:34] !== '0)
                        flag_mismatch("padding bits of tdata not zero");
                end
            end
            m_axis_tready <= (stall_left == 0) && (calm || $urandom_range(0, 99) >= 7);
        end
    end

    function automatic logic [23:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($urandom_range(0, 31)) - 24'd16;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic push_sample(input logic [23:0] s, input bit last);
        t_sample_item it;
        it.sample = s;
        it.last = last;
        sample_q.push_back(it);
        items_pushed++;
        if (last) columns_pushed++;
    endtask

    // Wait until the sender is drained and every result is back, then let the
    // back part finish any summary that may still be in flight.
    task automatic settle();
        while (sample_q.size() != 0 || s_axis_tvalid || stat_q.size() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_mode(input t_mode m);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        mode_now = m;
    endtask

    initial begin
        int len;
        int cols_in_phase;
        bit paused;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes in every mode, a one-sample sigma column.
        for (int m = 0; m < 8; m++) begin
            write_mode(t_mode'(m));
            push_sample(24'h7FFFFF, 1'b0);
            push_sample(24'h800000, 1'b0);
            push_sample(24'hFFFFFF, 1'b1);
            settle();
        end
        write_mode(MODE_SIGMA);
        push_sample(24'h800000, 1'b1);
        settle();

        // Mode change inside a column.
        write_mode(MODE_SUM);
        push_sample(24'h000123, 1'b0);
        push_sample(24'hFFF000, 1'b0);
        settle();
        write_mode(MODE_MIN);
        push_sample(24'h7FFFFF, 1'b1);
        settle();

        // Over-long column with no idling; the receiver holds off meanwhile,
        // then one more sample closes the column, which is read out as a sigma.
        write_mode(MODE_RSUM);
        calm = 1'b1;
        for (int i = 0; i < MaxRows + 6; i++) push_sample(pick_sample(), 1'b0);
        repeat (20) @(posedge i_clk);
        start_stall <= 1'b1;
        @(posedge i_clk);
        start_stall <= 1'b0;
        settle();
        calm = 1'b0;
        write_mode(MODE_SIGMA);
        push_sample(pick_sample(), 1'b1);
        settle();

        // Random columns, a new mode every few columns.
        paused = 1'b0;
        while (items_pushed < 1850) begin
            write_mode(t_mode'($urandom_range(0, 7)));
            cols_in_phase = $urandom_range(3, 10);
            for (int c = 0; c < cols_in_phase; c++) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 12);
                for (int i = 0; i < len; i++) push_sample(pick_sample(), i == len - 1);
            end
            if (!paused && items_pushed > 1400) begin
                while (sample_q.size() != 0 || s_axis_tvalid || stat_q.size() != 0)
                    @(posedge i_clk);
                paused = 1'b1;
            end
            settle();
        end

        settle();
        $display("Covered %0d samples in %0d columns across all eight modes, %0d results checked,",
                 items_in, columns_pushed, results_out);
        $display("including a column past the row limit and a long receiver hold-off.");
        if (errors == 0 && stat_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("Timed out with %0d results outstanding", stat_q.size());
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire
